// ===== hdl/dnsas_pkg.sv =====
package dnsas_pkg;

    localparam int MAX_PREF_NETS_DEF = 8;

    localparam int ADDR_W  = 64;
    localparam int FAM_W   = 2;
    localparam int CNT_CFG_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 64;
    localparam int IN_W    = 264;
    localparam int OUT_W   = 136;
    localparam int SCORE_W = 4;

    // address families
    localparam logic [FAM_W-1:0] FAM_NONE = 2'd0;
    localparam logic [FAM_W-1:0] FAM_V4   = 2'd1;
    localparam logic [FAM_W-1:0] FAM_V6   = 2'd2;

    // operations carried in tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    // result status
    localparam logic [1:0] ST_NO_UPDATE   = 2'd0;
    localparam logic [1:0] ST_NO_ADDR     = 2'd1;
    localparam logic [1:0] ST_CUR_MISSING = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAMILY_PRIORITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_DUPLICATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREF_NET_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_FAMILY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_ADDR_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_ADDR_LOW  = 3'd5;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 4'd15;

    typedef struct packed {
        logic [FAM_W-1:0]  family;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [ADDR_W-1:0] mask_high;
        logic [ADDR_W-1:0] mask_low;
    } tbl_entry_t;

    typedef struct packed {
        logic       en;
        logic [2:0] idx;
        tbl_entry_t entry;
    } tbl_wr_t;

    typedef struct packed {
        logic              start;
        logic [FAM_W-1:0]  family;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
    } match_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } match_rsp_t;

endpackage

// ===== hdl/dnsas_matcher.sv =====
module dnsas_matcher #(
    parameter int MAX_PREF_NETS = dnsas_pkg::MAX_PREF_NETS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dnsas_pkg::tbl_wr_t                  wr,
    input  dnsas_pkg::match_req_t               req,
    input  logic [dnsas_pkg::CNT_CFG_W-1:0]     net_count,
    output dnsas_pkg::match_rsp_t               rsp
);
    import dnsas_pkg::*;

    localparam int IDX_W = (MAX_PREF_NETS > 1) ? $clog2(MAX_PREF_NETS) : 1;
    localparam int CNT_W = $clog2(MAX_PREF_NETS + 1);

    tbl_entry_t mem [MAX_PREF_NETS];
    tbl_entry_t rd_data_reg;

    logic             busy_reg, busy_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             hit_reg, hit_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] n_lim;
    logic             rd_en;
    logic             done;
    logic             entry_hit;

    assign n_lim = (32'(net_count) > MAX_PREF_NETS) ? CNT_W'(MAX_PREF_NETS)
                                                     : CNT_W'(net_count);
    assign rd_en = busy_reg && (iss_reg != n_reg);
    assign done  = busy_reg && !rd_en && !rd_vld_reg;

    // masked compare against one table entry per cycle
    always_comb
    begin
        entry_hit = 1'b0;
        if (rd_data_reg.family == req.family)
        begin
            if (req.family == FAM_V4)
                entry_hit = ((req.addr_low[31:0] ^ rd_data_reg.addr_low[31:0])
                             & rd_data_reg.mask_low[31:0]) == 32'd0;
            else
                entry_hit = (((req.addr_high ^ rd_data_reg.addr_high) & rd_data_reg.mask_high)
                           | ((req.addr_low ^ rd_data_reg.addr_low) & rd_data_reg.mask_low))
                           == {ADDR_W{1'b0}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (32'(wr.idx) < MAX_PREF_NETS))
            mem[IDX_W'(wr.idx)] <= wr.entry;
        if (rd_en)
            rd_data_reg <= mem[iss_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        busy_next   = busy_reg;
        rd_vld_next = rd_vld_reg;
        hit_next    = hit_reg;
        iss_next    = iss_reg;
        n_next      = n_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            rd_vld_next = 1'b0;
            hit_next    = 1'b0;
            iss_next    = '0;
            n_next      = n_lim;
        end
        else if (busy_reg)
        begin
            rd_vld_next = rd_en;
            if (rd_en)
                iss_next = iss_reg + CNT_W'(1);
            if (rd_vld_reg && entry_hit)
                hit_next = 1'b1;
            if (done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
            iss_reg    <= '0;
            n_reg      <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            rd_vld_reg <= rd_vld_next;
            hit_reg    <= hit_next;
            iss_reg    <= iss_next;
            n_reg      <= n_next;
        end
    end

    assign rsp.done = done;
    assign rsp.hit  = hit_reg;

endmodule

// ===== hdl/dns_answer_address_selector_top.sv =====
// Load word, dropped record or other type not ending a response: next word on the next cycle.
// Answer record: scan, then scoring, then final pick on the last record of a response
// unless it scores top; the scan covers the table entries in use (0 to MAX_PREF_NETS) and
// reads and compares one entry per cycle. Other type ending a response: final pick.
// One word is in work at a time; a finished result waits in the output register and stalls.
// Reset (rst_n, async, active low) clears sequencer, configuration, per-response state only.
module dns_answer_address_selector_top #(
    parameter int MAX_PREF_NETS = dnsas_pkg::MAX_PREF_NETS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // record_type, addr_high, addr_low, in_use_elsewhere, net_index, net_family,
    // mask_high, mask_low
    input  logic [dnsas_pkg::IN_W-1:0]        s_axis_tdata,
    // operation
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status, chosen_family, chosen_addr_high, chosen_addr_low, rotate_first, zero pad
    output logic [dnsas_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [dnsas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dnsas_pkg::CFG_W-1:0]       cfg_data
);
    import dnsas_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SCORE = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    localparam int OUT_PAD = OUT_W - 133;

    state_t state_reg, state_next;

    // configuration
    logic [FAM_W-1:0]     fam_prio_reg;
    logic                 acc_dup_reg;
    logic [CNT_CFG_W-1:0] net_cnt_reg;
    logic [FAM_W-1:0]     cur_fam_reg;
    logic [ADDR_W-1:0]    cur_hi_reg;
    logic [ADDR_W-1:0]    cur_lo_reg;

    // current record
    logic [FAM_W-1:0]  type_reg;
    logic [ADDR_W-1:0] hi_reg;
    logic [ADDR_W-1:0] lo_reg;
    logic              used_reg;
    logic              last_reg;

    // per-response control
    logic best_vld_reg, best_vld_next;
    logic v4_vld_reg, v4_vld_next;
    logic have_v6_reg, have_v6_next;
    logic matched_reg, matched_next;
    logic done_reg, done_next;
    logic out_vld_reg, out_vld_next;

    // per-response payload
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [31:0]        v4_reg, v4_next;
    logic [ADDR_W-1:0]  v6_hi_reg, v6_hi_next;
    logic [ADDR_W-1:0]  v6_lo_reg, v6_lo_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic               accept;
    logic [FAM_W-1:0]   in_type;
    logic               in_scored;
    logic               out_free;
    logic               cur_hit;
    logic               skip;
    logic [SCORE_W-1:0] score;
    logic               better;
    logic               top_score;
    logic               pick_v4;
    logic [1:0]         fin_st;

    tbl_wr_t    tbl_wr;
    match_req_t mreq;
    match_rsp_t mrsp;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_type       = s_axis_tdata[1:0];
    assign in_scored     = (in_type == FAM_V4) || (in_type == FAM_V6);
    assign out_free      = !out_vld_reg || m_axis_tready;

    assign tbl_wr.en              = accept && (s_axis_tuser == OP_LOAD);
    assign tbl_wr.idx             = s_axis_tdata[133:131];
    assign tbl_wr.entry.family    = s_axis_tdata[135:134];
    assign tbl_wr.entry.addr_high = s_axis_tdata[65:2];
    assign tbl_wr.entry.addr_low  = s_axis_tdata[129:66];
    assign tbl_wr.entry.mask_high = s_axis_tdata[199:136];
    assign tbl_wr.entry.mask_low  = s_axis_tdata[263:200];

    assign mreq.start     = accept && (s_axis_tuser == OP_RECORD) && !done_reg && in_scored;
    assign mreq.family    = type_reg;
    assign mreq.addr_high = hi_reg;
    assign mreq.addr_low  = lo_reg;

    dnsas_matcher #(
        .MAX_PREF_NETS(MAX_PREF_NETS)
    ) u_matcher (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .req      (mreq),
        .net_count(net_cnt_reg),
        .rsp      (mrsp)
    );

    // score bits weigh 8 (family), 4 (network), 2 (free), 1 (current)
    always_comb
    begin
        cur_hit = 1'b0;
        if (type_reg == cur_fam_reg)
        begin
            if (type_reg == FAM_V4)
                cur_hit = lo_reg[31:0] == cur_lo_reg[31:0];
            else
                cur_hit = (hi_reg == cur_hi_reg) && (lo_reg == cur_lo_reg);
        end
    end

    assign skip      = used_reg && !acc_dup_reg;
    assign score     = {type_reg == fam_prio_reg, mrsp.hit, !used_reg, cur_hit};
    assign better    = !skip && (!best_vld_reg || (score > best_score_reg));
    assign top_score = better && (score == SCORE_MAX);
    assign pick_v4   = (fam_prio_reg == FAM_V4) ? v4_vld_reg : !have_v6_reg;
    assign fin_st    = matched_reg ? ST_NO_UPDATE : ST_CUR_MISSING;

    always_comb
    begin
        state_next      = state_reg;
        best_vld_next   = best_vld_reg;
        v4_vld_next     = v4_vld_reg;
        have_v6_next    = have_v6_reg;
        matched_next    = matched_reg;
        done_next       = done_reg;
        out_vld_next    = out_vld_reg && !m_axis_tready;
        best_score_next = best_score_reg;
        v4_next         = v4_reg;
        v6_hi_next      = v6_hi_reg;
        v6_lo_next      = v6_lo_reg;
        out_data_next   = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (s_axis_tuser == OP_RECORD))
                begin
                    if (done_reg)
                    begin
                        // drop records until the response ends
                        if (s_axis_tlast)
                            done_next = 1'b0;
                    end
                    else if (in_scored)
                        state_next = S_SCAN;
                    else if (s_axis_tlast)
                        state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                if (mrsp.done)
                    state_next = S_SCORE;
            end
            S_SCORE:
            begin
                if (top_score)
                begin
                    // hold until the output register frees up
                    if (out_free)
                    begin
                        out_vld_next  = 1'b1;
                        out_data_next = {OUT_PAD'(0), 1'b0, {ADDR_W{1'b0}},
                                         {ADDR_W{1'b0}}, FAM_NONE, ST_NO_UPDATE};
                        best_vld_next = 1'b0;
                        v4_vld_next   = 1'b0;
                        have_v6_next  = 1'b0;
                        matched_next  = 1'b0;
                        done_next     = !last_reg;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    if (better)
                    begin
                        best_vld_next   = 1'b1;
                        best_score_next = score;
                        matched_next    = cur_hit;
                        if (type_reg == FAM_V4)
                        begin
                            v4_next     = lo_reg[31:0];
                            v4_vld_next = 1'b1;
                        end
                        else
                        begin
                            v6_hi_next   = hi_reg;
                            v6_lo_next   = lo_reg;
                            have_v6_next = 1'b1;
                        end
                    end
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    if (!v4_vld_reg && !have_v6_reg)
                        out_data_next = {OUT_PAD'(0), 1'b0, {ADDR_W{1'b0}},
                                         {ADDR_W{1'b0}}, FAM_NONE, ST_NO_ADDR};
                    else if (pick_v4)
                        out_data_next = {OUT_PAD'(0), !matched_reg, {32'd0, v4_reg},
                                         {ADDR_W{1'b0}}, FAM_V4, fin_st};
                    else
                        out_data_next = {OUT_PAD'(0), !matched_reg, v6_lo_reg,
                                         v6_hi_reg, FAM_V6, fin_st};
                    best_vld_next = 1'b0;
                    v4_vld_next   = 1'b0;
                    have_v6_next  = 1'b0;
                    matched_next  = 1'b0;
                    done_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            best_vld_reg <= 1'b0;
            v4_vld_reg   <= 1'b0;
            have_v6_reg  <= 1'b0;
            matched_reg  <= 1'b0;
            done_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            best_vld_reg <= best_vld_next;
            v4_vld_reg   <= v4_vld_next;
            have_v6_reg  <= have_v6_next;
            matched_reg  <= matched_next;
            done_reg     <= done_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_score_reg <= best_score_next;
        v4_reg         <= v4_next;
        v6_hi_reg      <= v6_hi_next;
        v6_lo_reg      <= v6_lo_next;
        out_data_reg   <= out_data_next;
        if (accept)
        begin
            type_reg <= in_type;
            hi_reg   <= s_axis_tdata[65:2];
            // IPv4 uses only the low 32 bits
            lo_reg   <= (in_type == FAM_V4) ? {32'd0, s_axis_tdata[97:66]}
                                            : s_axis_tdata[129:66];
            used_reg <= s_axis_tdata[130];
            last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fam_prio_reg <= FAM_NONE;
            acc_dup_reg  <= 1'b0;
            net_cnt_reg  <= '0;
            cur_fam_reg  <= FAM_NONE;
            cur_hi_reg   <= '0;
            cur_lo_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAMILY_PRIORITY:   fam_prio_reg <= cfg_data[FAM_W-1:0];
                CFG_ACCEPT_DUPLICATE:  acc_dup_reg  <= cfg_data[0];
                CFG_PREF_NET_COUNT:    net_cnt_reg  <= cfg_data[CNT_CFG_W-1:0];
                CFG_CURRENT_FAMILY:    cur_fam_reg  <= cfg_data[FAM_W-1:0];
                CFG_CURRENT_ADDR_HIGH: cur_hi_reg   <= cfg_data;
                CFG_CURRENT_ADDR_LOW:  cur_lo_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> (state_reg == S_SCAN))
        else $error("table scan finished outside the scan state");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> ($past(state_reg) == S_SCORE || $past(state_reg) == S_FIN))
        else $error("result raised outside scoring or final pick");

    a_top_score_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCORE && top_score && !out_free) |=> (state_reg == S_SCORE))
        else $error("top score left scoring while the output was full");

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (!best_vld_reg && !done_reg && out_vld_reg))
        else $error("response state not cleared after final pick");
`endif

endmodule
